### src/imrot_pkg.sv
// Shared types and constants for the frame rotation engine.
`timescale 1ns / 1ps

package imrot_pkg;

   localparam int CFG_W   = 7;
   localparam int MODE_W  = 2;
   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 3 * CHAN_W;

   localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_ROTATION_MODE = 2'd2;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_FETCH = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_CW      = 2'd0,
      MODE_CCW     = 2'd1,
      MODE_HALF    = 2'd2,
      MODE_INVALID = 2'd3
   } rotate_mode_type;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
      logic              fetch_error;
   } rsp_item_type;

endpackage

### src/imrot_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module imrot_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/image_rotate_90_180.sv
// Frame rotation engine: top level with frame store, counters and result stage.
//
// Usage:
//   req_* carries one item per transfer: action load writes one RGB pixel in
//   source raster order; action fetch returns the next pixel of the rotated
//   frame in destination raster order on rsp_*. Loads return nothing.
//   csr_* writes image_width (0), image_height (1) and rotation_mode (2);
//   write them only while the block is idle. A size write restarts loading,
//   a mode write restarts fetching from the first destination pixel.
//   A fetch result appears on rsp_* in the cycle after its transfer.
//   Throughput: one item per cycle while req_stall is low, set by the single
//   read port of the frame store and its registered read data.
//   A fetch before the frame is fully loaded, or under the invalid mode,
//   returns a result with fetch_error set and zero pixel data.
//   frame_last marks the final rotated pixel; the frame must then be loaded
//   again.
//   Reset: clears all counters, the frame-ready flag and the result valid
//   flag, and sets width and height to 64 and the mode to clockwise. The frame
//   store is not cleared and needs no clearing pass.
//   Stall: while rsp_stall holds a waiting result, req_stall is raised and
//   the result stays unchanged.
`timescale 1ns / 1ps

module image_rotate_90_180
   import imrot_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);

   logic [CFG_W-1:0] image_width_ff, image_width_in;
   logic [CFG_W-1:0] image_height_ff, image_height_in;
   rotate_mode_type  rotation_mode_ff, rotation_mode_in;
   logic [ROW_W-1:0] load_row_ff, load_row_in;
   logic [COL_W-1:0] load_col_ff, load_col_in;
   logic [CNT_W-1:0] emit_row_ff, emit_row_in;
   logic [CNT_W-1:0] emit_col_ff, emit_col_in;
   logic             frame_ready_ff, frame_ready_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_error_ff, rsp_error_in;

   logic [DIM_W-1:0]   w_eff, h_eff, out_w, out_h;
   logic [DIM_W-1:0]   src_row, src_col;
   logic               req_fire, do_load, do_fetch;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [PIXEL_W-1:0] rd_data;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = DIM_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = DIM_W'(image_height_ff);
      end
   end

   always_comb begin
      case (rotation_mode_ff)
         MODE_CW: begin
            out_w   = h_eff;
            out_h   = w_eff;
            src_row = h_eff - DIM_W'(1) - DIM_W'(emit_col_ff);
            src_col = DIM_W'(emit_row_ff);
         end
         MODE_CCW: begin
            out_w   = h_eff;
            out_h   = w_eff;
            src_row = DIM_W'(emit_col_ff);
            src_col = w_eff - DIM_W'(1) - DIM_W'(emit_row_ff);
         end
         default: begin
            out_w   = w_eff;
            out_h   = h_eff;
            src_row = h_eff - DIM_W'(1) - DIM_W'(emit_row_ff);
            src_col = w_eff - DIM_W'(1) - DIM_W'(emit_col_ff);
         end
      endcase
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign do_load   = req_fire && (req_data.action == ACTION_LOAD) && !frame_ready_ff;
   assign do_fetch  = req_fire && (req_data.action == ACTION_FETCH) && frame_ready_ff
                      && (rotation_mode_ff != MODE_INVALID);

   assign wr_en   = do_load;
   assign wr_addr = ADDR_W'(ADDR_W'(load_row_ff) * ADDR_W'(MAX_WIDTH))
                    + ADDR_W'(load_col_ff);
   assign rd_en   = do_fetch;
   assign rd_addr = ADDR_W'(ADDR_W'(src_row[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH))
                    + ADDR_W'(src_col[COL_W-1:0]);

   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      rotation_mode_in = rotation_mode_ff;
      load_row_in      = load_row_ff;
      load_col_in      = load_col_ff;
      emit_row_in      = emit_row_ff;
      emit_col_in      = emit_col_ff;
      frame_ready_in   = frame_ready_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_last_in      = rsp_last_ff;
      rsp_error_in     = rsp_error_ff;

      if (do_load) begin
         if (DIM_W'(load_col_ff) != w_eff - DIM_W'(1)) begin
            load_col_in = COL_W'(load_col_ff + 1'b1);
         end else begin
            load_col_in = '0;
            if (DIM_W'(load_row_ff) != h_eff - DIM_W'(1)) begin
               load_row_in = ROW_W'(load_row_ff + 1'b1);
            end else begin
               load_row_in    = '0;
               frame_ready_in = 1'b1;
               emit_row_in    = '0;
               emit_col_in    = '0;
            end
         end
      end

      if (req_fire && (req_data.action == ACTION_FETCH)) begin
         rsp_valid_in = 1'b1;
         rsp_error_in = !do_fetch;
         rsp_last_in  = 1'b0;
      end

      if (do_fetch) begin
         if (DIM_W'(emit_col_ff) != out_w - DIM_W'(1)) begin
            emit_col_in = CNT_W'(emit_col_ff + 1'b1);
         end else begin
            emit_col_in = '0;
            if (DIM_W'(emit_row_ff) != out_h - DIM_W'(1)) begin
               emit_row_in = CNT_W'(emit_row_ff + 1'b1);
            end else begin
               emit_row_in    = '0;
               rsp_last_in    = 1'b1;
               frame_ready_in = 1'b0;
            end
         end
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT: begin
               if (csr_index == CSR_IMAGE_WIDTH) begin
                  image_width_in = csr_wdata;
               end else begin
                  image_height_in = csr_wdata;
               end
               load_row_in    = '0;
               load_col_in    = '0;
               emit_row_in    = '0;
               emit_col_in    = '0;
               frame_ready_in = 1'b0;
            end
            CSR_ROTATION_MODE: begin
               rotation_mode_in = rotate_mode_type'(csr_wdata[MODE_W-1:0]);
               emit_row_in      = '0;
               emit_col_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= DIM_RESET;
         image_height_ff  <= DIM_RESET;
         rotation_mode_ff <= MODE_CW;
         load_row_ff      <= '0;
         load_col_ff      <= '0;
         emit_row_ff      <= '0;
         emit_col_ff      <= '0;
         frame_ready_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         rotation_mode_ff <= rotation_mode_in;
         load_row_ff      <= load_row_in;
         load_col_ff      <= load_col_in;
         emit_row_ff      <= emit_row_in;
         emit_col_ff      <= emit_col_in;
         frame_ready_ff   <= frame_ready_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   imrot_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.red_in, req_data.green_in, req_data.blue_in}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.red_out      = rsp_error_ff ? '0 : rd_data[3*CHAN_W-1:2*CHAN_W];
   assign rsp_data.green_out    = rsp_error_ff ? '0 : rd_data[2*CHAN_W-1:CHAN_W];
   assign rsp_data.blue_out     = rsp_error_ff ? '0 : rd_data[CHAN_W-1:0];
   assign rsp_data.frame_last   = rsp_last_ff;
   assign rsp_data.fetch_error  = rsp_error_ff;

   a_last_not_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> !rsp_data.fetch_error)
      else $error("frame_last set on an error result");

   a_last_clears_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> !frame_ready_ff)
      else $error("frame still ready after its final pixel");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with an empty result stage");

   a_ready_load_idle: assert property (@(posedge clock) disable iff (reset)
      frame_ready_ff |-> (load_row_ff == '0) && (load_col_ff == '0))
      else $error("load counters moved while the frame is ready");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the frame rotation engine: load, rotate and fetch under stalls.
`timescale 1ns / 1ps

module testbench;
   import imrot_pkg::*;

   localparam int MAX_DIM       = 64;
   localparam int ITEM_TARGET   = 1400;
   localparam int SETTLE_CYCLES = 4;
   localparam int WATCHDOG_MAX  = 2000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_item_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_item_type       rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [CFG_W-1:0]   csr_wdata = '0;

   image_rotate_90_180 #(
      .MAX_WIDTH  (MAX_DIM),
      .MAX_HEIGHT (MAX_DIM)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // expected behavior of the block
   logic [PIXEL_W-1:0] frame_pixels [0:MAX_DIM*MAX_DIM-1];
   logic [CFG_W-1:0]   cfg_width = DIM_RESET;
   logic [CFG_W-1:0]   cfg_height = DIM_RESET;
   rotate_mode_type    cfg_mode = MODE_CW;
   int                 load_row = 0, load_col = 0, emit_row = 0, emit_col = 0;
   bit                 frame_ready = 1'b0;

   req_item_type       req_backlog [$];
   rsp_item_type       expected_pixels [$];
   rsp_item_type       want;
   logic               req_taken = 1'b0;
   int                 idle_pct = 0, stall_pct = 0;
   int                 mismatches = 0, quiet_cycles = 0, generated = 0;
   int                 frames = 0, loads_seen = 0, fetches_seen = 0;
   int                 errors_seen = 0, frame_ends = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int dim_of(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic clear_progress();
      load_row = 0;
      load_col = 0;
      emit_row = 0;
      emit_col = 0;
      frame_ready = 1'b0;
   endtask

   task automatic rotate_predict(input req_item_type item);
      int w, h, out_w, out_h, src_r, src_c;
      rsp_item_type res;
      w = dim_of(cfg_width);
      h = dim_of(cfg_height);
      if (item.action == ACTION_LOAD) begin
         if (!frame_ready) begin
            frame_pixels[load_row * MAX_DIM + load_col] =
               {item.red_in, item.green_in, item.blue_in};
            if (load_col + 1 < w) begin
               load_col++;
            end else begin
               load_col = 0;
               if (load_row + 1 < h) begin
                  load_row++;
               end else begin
                  load_row = 0;
                  frame_ready = 1'b1;
                  emit_row = 0;
                  emit_col = 0;
               end
            end
         end
      end else begin
         res = '0;
         if (!frame_ready || cfg_mode == MODE_INVALID) begin
            res.fetch_error = 1'b1;
         end else begin
            if (cfg_mode == MODE_HALF) begin
               out_w = w;
               out_h = h;
               src_r = h - 1 - emit_row;
               src_c = w - 1 - emit_col;
            end else begin
               out_w = h;
               out_h = w;
               if (cfg_mode == MODE_CW) begin
                  src_r = h - 1 - emit_col;
                  src_c = emit_row;
               end else begin
                  src_r = emit_col;
                  src_c = w - 1 - emit_row;
               end
            end
            {res.red_out, res.green_out, res.blue_out} = frame_pixels[src_r * MAX_DIM + src_c];
            if (emit_col + 1 < out_w) begin
               emit_col++;
            end else begin
               emit_col = 0;
               if (emit_row + 1 < out_h) begin
                  emit_row++;
               end else begin
                  emit_row = 0;
                  res.frame_last = 1'b1;
                  frame_ready = 1'b0;
               end
            end
         end
         expected_pixels.push_back(res);
      end
   endtask

   task automatic check_field(input string name, input logic [CHAN_W-1:0] exp_val,
                              input logic [CHAN_W-1:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            if (req_data.action == ACTION_LOAD) loads_seen++;
            rotate_predict(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            fetches_seen++;
            if (rsp_data.fetch_error) errors_seen++;
            if (rsp_data.frame_last) frame_ends++;
            if (expected_pixels.size() == 0) begin
               $error("result transfer with no fetch outstanding");
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red_out", want.red_out, rsp_data.red_out);
               check_field("green_out", want.green_out, rsp_data.green_out);
               check_field("blue_out", want.blue_out, rsp_data.blue_out);
               check_field("frame_last", CHAN_W'(want.frame_last),
                           CHAN_W'(rsp_data.frame_last));
               check_field("fetch_error", CHAN_W'(want.fetch_error),
                           CHAN_W'(rsp_data.fetch_error));
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic push_item(input logic action, input logic [PIXEL_W-1:0] pixel);
      req_item_type item;
      item.action = action;
      {item.red_in, item.green_in, item.blue_in} = pixel;
      req_backlog.push_back(item);
      generated++;
   endtask

   task automatic push_loads(input int count);
      repeat (count) push_item(ACTION_LOAD, PIXEL_W'($urandom));
   endtask

   task automatic push_fetches(input int count);
      repeat (count) push_item(ACTION_FETCH, PIXEL_W'($urandom));
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_IMAGE_WIDTH: begin
            cfg_width = value;
            clear_progress();
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = value;
            clear_progress();
         end
         CSR_ROTATION_MODE: begin
            cfg_mode = rotate_mode_type'(value[MODE_W-1:0]);
            emit_row = 0;
            emit_col = 0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_mode(input rotate_mode_type mode);
      logic [CFG_W-MODE_W-1:0] pad;
      pad = (CFG_W-MODE_W)'($urandom);
      csr_write(CSR_ROTATION_MODE, {pad, mode});
   endtask

   function automatic rotate_mode_type pick_mode();
      if ($urandom_range(9) == 0) return MODE_INVALID;
      return rotate_mode_type'($urandom_range(0, 2));
   endfunction

   initial begin : stimulus
      int sel, w, h, n, cut;
      logic [CFG_W-1:0] w_code, h_code;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fetch before any frame, pixel extremes, load while ready,
      // mode change mid-frame, fetch past the frame, zero size, invalid mode
      push_item(ACTION_FETCH, 24'hFFFFFF);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 7'd3);
      csr_write(CSR_IMAGE_HEIGHT, 7'd2);
      set_mode(MODE_CW);
      push_item(ACTION_LOAD, 24'h000000);
      push_item(ACTION_LOAD, 24'hFFFFFF);
      push_item(ACTION_LOAD, 24'hFF0000);
      push_item(ACTION_FETCH, 24'h000000);
      push_item(ACTION_LOAD, 24'h00FF00);
      push_item(ACTION_LOAD, 24'h0000FF);
      push_loads(1);
      push_fetches(2);
      push_item(ACTION_LOAD, 24'hFFFFFF);
      wait_idle();
      set_mode(MODE_CCW);
      push_fetches(7);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 7'd0);
      csr_write(CSR_IMAGE_HEIGHT, 7'd1);
      set_mode(MODE_INVALID);
      push_loads(1);
      push_fetches(1);
      wait_idle();
      set_mode(MODE_HALF);
      push_fetches(1);
      wait_idle();
      csr_write(CSR_UNUSED, 7'h7F);

      while (generated < ITEM_TARGET) begin
         frames++;
         case (frames % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         sel = $urandom_range(0, 19);
         case (sel)
            0: begin w_code = 7'd64; h_code = CFG_W'($urandom_range(1, 3)); end
            1: begin w_code = CFG_W'($urandom_range(1, 3)); h_code = 7'd64; end
            2: begin w_code = CFG_W'($urandom_range(65, 127)); h_code = CFG_W'($urandom_range(0, 2)); end
            3: begin w_code = CFG_W'($urandom_range(0, 2)); h_code = CFG_W'($urandom_range(65, 127)); end
            4: begin w_code = 7'd0; h_code = CFG_W'($urandom_range(0, 8)); end
            default: begin
               w_code = CFG_W'($urandom_range(1, 8));
               h_code = CFG_W'($urandom_range(1, 8));
            end
         endcase
         if ($urandom_range(1)) begin
            csr_write(CSR_IMAGE_WIDTH, w_code);
            csr_write(CSR_IMAGE_HEIGHT, h_code);
         end else begin
            csr_write(CSR_IMAGE_HEIGHT, h_code);
            csr_write(CSR_IMAGE_WIDTH, w_code);
         end
         set_mode(pick_mode());
         if ($urandom_range(7) == 0) csr_write(CSR_UNUSED, CFG_W'($urandom));
         w = dim_of(w_code);
         h = dim_of(h_code);
         n = w * h;

         if ($urandom_range(9) == 0) begin
            // abandoned frame: partial load, early fetch, then resize
            push_loads($urandom_range(0, n - 1));
            push_fetches($urandom_range(0, 1));
         end else begin
            cut = $urandom_range(0, n - 1);
            push_loads(cut);
            if ($urandom_range(7) == 0) push_fetches(1);
            push_loads(n - cut);
            if ($urandom_range(5) == 0) push_loads(1);
            if ($urandom_range(3) == 0) begin
               push_fetches($urandom_range(1, n));
               wait_idle();
               set_mode(pick_mode());
            end
            push_fetches(n);
            if ($urandom_range(5) == 0) push_fetches(1);
         end
         wait_idle();
      end

      wait_idle();
      $display("Covered %0d random frames: %0d loads, %0d fetch results", frames, loads_seen,
               fetches_seen);
      $display("  of which %0d flagged errors and %0d closed a rotated frame", errors_seen,
               frame_ends);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
